FILE: hdl/lfps_pkg.sv
// Shared types and constants of the line-follower PID steering block.
package lfps_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd4;

	localparam logic [6:0]  BASE_SPEED_RST  = 7'd30;
	localparam logic [15:0] PROP_GAIN_RST   = 16'd3840;
	localparam logic [15:0] INTEG_GAIN_RST  = 16'd128;
	localparam logic [15:0] DERIV_GAIN_RST  = 16'd2048;
	localparam logic [14:0] INTEG_LIMIT_RST = 15'd2000;

	// Stream widths
	localparam int SENSOR_W = 6;
	localparam int IN_W     = 8;
	localparam int OUT_W    = 40;

	// Datapath widths
	localparam int ACC_W    = 36;
	localparam int DIV_W    = 36;
	localparam int DVS_W    = 15;
	localparam int MUL_W    = 25;
	localparam int PROD_W   = 50;
	localparam int DSTEP_W  = 6;
	localparam int ERR_DIV_BITS = 12;

	localparam logic [DSTEP_W-1:0] ERR_DIV_STEPS = 6'd12;

	// Division of the PID sum by 25600 = 1024 * 25: the magnitude is shifted right by ten
	// and multiplied by the rounded-up reciprocal of 25 scaled by 2^28. The quotient is
	// exact for every magnitude below 2^33, which covers the whole PID range.
	localparam int ADJ_SHIFT       = 10;
	localparam int ADJ_QIN_W       = 23;
	localparam int ADJ_RECIP_SHIFT = 28;
	localparam logic [23:0] ADJ_RECIP = 24'd10737419;

	// Duty shaping
	localparam int DUTY_W = 23;
	localparam logic signed [DUTY_W-1:0] DUTY_KNEE = 23'sd100;
	localparam logic signed [DUTY_W-1:0] DUTY_MAX  = 23'sd150;
	localparam logic signed [DUTY_W-1:0] DUTY_MIN  = -23'sd50;
	localparam logic [7:0] DIV3_RECIP = 8'd171;
	localparam int DIV3_SHIFT = 9;

	// Sequencer states
	typedef enum logic [12:0] {
		ST_IDLE  = 13'b0_0000_0000_0001,
		ST_SCAN  = 13'b0_0000_0000_0010,
		ST_EPREP = 13'b0_0000_0000_0100,
		ST_EDIV  = 13'b0_0000_0000_1000,
		ST_ERR   = 13'b0_0000_0001_0000,
		ST_MULP  = 13'b0_0000_0010_0000,
		ST_MULI  = 13'b0_0000_0100_0000,
		ST_MULD  = 13'b0_0000_1000_0000,
		ST_ACCD  = 13'b0_0001_0000_0000,
		ST_APREP = 13'b0_0010_0000_0000,
		ST_AMUL  = 13'b0_0100_0000_0000,
		ST_ADIV  = 13'b0_1000_0000_0000,
		ST_SHAPE = 13'b1_0000_0000_0000
	} state_t;

endpackage

FILE: hdl/line_follower_pid_steering.sv
// Top level of the line-follower PID steering block: sequencer, shared datapath and ports.
//
// Usage: each control tick a transaction on the slave stream (s_tvalid, s_tready, s_tdata)
// delivers the line-sensor bits; a sensor whose bit is low sees the line. For every input
// transaction the block returns exactly one transaction on the master stream carrying the
// forward and reverse duties of both wheels and the line error of this tick.
// Gains, base speed and integral limit are written through the plain write port
// (cfg_wr_en, cfg_index, cfg_data) while no tick is in progress.
// Timing: the sensors are scanned one per cycle, the average goes through a 12-step
// shift-subtract divider, and the three PID products share one 25 x 25 bit multiplier,
// which also divides the PID sum by 25600 as a shift by ten and a reciprocal product.
// The averaging division is skipped when no sensor sees the line, and the block is ready
// for a new input once the result has been registered. s_tready is high only while
// the sequencer is idle. The result sits in an output register: a stalled receiver does not
// stop the block from taking the next input, but the following result waits in the final
// stage until the register is free.
// Reset (arst_n low) restores the register defaults, clears the previous error and the
// error sum, and empties the output register.
module line_follower_pid_steering #(
	parameter int SENSOR_COUNT = 6
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// s_tdata: [5:0] sensor_bits, [7:6] zero
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lfps_pkg::IN_W-1:0]       s_tdata,
	// m_tdata: [5:0] right_fwd_duty, [10:6] right_rev_duty, [16:11] left_fwd_duty,
	//          [21:17] left_rev_duty, [37:22] line_error, [39:38] zero
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [lfps_pkg::OUT_W-1:0]      m_tdata,
	input  logic                            cfg_wr_en,
	input  logic [lfps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lfps_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lfps_pkg::*;

	localparam int HALF  = SENSOR_COUNT / 2;
	localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
	localparam int SCNT_W = $clog2(SENSOR_COUNT + 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SENSOR_COUNT - 1);

	// Weight of a sensor position times 100; the middle position is skipped so that
	// the weights run symmetrically with no zero.
	function automatic logic signed [12:0] weight100(input logic [IDX_W-1:0] i);
		logic signed [5:0] w;
		if (int'(i) < HALF) begin
			w = 6'(int'(i) - HALF);
		end else begin
			w = 6'(int'(i) - HALF + 1);
		end
		return 13'(w) * 13'sd100;
	endfunction

	// Compress the duty above 100 and below 0 by half, then clamp.
	function automatic logic signed [DUTY_W-1:0] shape_duty(input logic signed [DUTY_W-1:0] d);
		logic signed [DUTY_W-1:0] t;
		t = d;
		if (t > DUTY_KNEE) begin
			t = DUTY_KNEE + ((t - DUTY_KNEE) >>> 1);
		end
		if (t < 0) begin
			t = (t + DUTY_W'(1)) >>> 1;
		end
		if (t > DUTY_MAX) begin
			t = DUTY_MAX;
		end
		if (t < DUTY_MIN) begin
			t = DUTY_MIN;
		end
		return t;
	endfunction

	// Exact division by three for values below 256.
	function automatic logic [6:0] div3(input logic [7:0] x);
		logic [15:0] p;
		p = 16'(x) * 16'(DIV3_RECIP);
		return 7'(p >> DIV3_SHIFT);
	endfunction

	state_t state_q;

	// Configuration registers
	logic [6:0]  base_speed_q;
	logic [15:0] prop_gain_q;
	logic [15:0] integ_gain_q;
	logic [15:0] deriv_gain_q;
	logic [14:0] integ_limit_q;

	// Controller state
	logic signed [15:0] prev_error_q;
	logic signed [15:0] error_sum_q;

	// Working registers
	logic [SENSOR_W-1:0]       sensor_q;
	logic [IDX_W-1:0]          idx_q;
	logic [SCNT_W-1:0]         cnt_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [15:0]        err_q;
	logic signed [16:0]        diff_q;
	logic [DVS_W-1:0]          rem_q;
	logic [DIV_W-1:0]          quo_q;
	logic [DVS_W-1:0]          divisor_q;
	logic [DSTEP_W-1:0]        div_cnt_q;
	logic                      neg_q;

	// Output register
	logic                      m_tvalid_q;
	logic [OUT_W-1:0]          m_tdata_q;

	// Combinational datapath
	logic [SENSOR_W-1:0]       sensor_shift;
	logic                      sensor_hit;
	logic [DIV_W-1:0]          acc_mag;
	logic [DVS_W:0]            div_shifted;
	logic [DVS_W:0]            div_trial;
	logic                      div_qbit;
	logic signed [DIV_W-1:0]   quo_signed;
	logic signed [15:0]        e_next;
	logic signed [16:0]        sum_raw;
	logic signed [16:0]        lim_pos;
	logic signed [16:0]        lim_neg;
	logic signed [15:0]        sum_next;
	logic signed [MUL_W-1:0]   mul_a;
	logic signed [MUL_W-1:0]   mul_b;
	logic signed [DUTY_W-1:0]  adj;
	logic signed [DUTY_W-1:0]  base_ext;
	logic signed [DUTY_W-1:0]  right_d;
	logic signed [DUTY_W-1:0]  left_d;
	logic [5:0]                right_fwd;
	logic [4:0]                right_rev;
	logic [5:0]                left_fwd;
	logic [4:0]                left_rev;
	logic                      out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;

	// Sensors beyond the input width shift in as zero and therefore count as active.
	assign sensor_shift = sensor_q >> idx_q;
	assign sensor_hit   = !sensor_shift[0];

	assign acc_mag = acc_q[ACC_W-1] ? $unsigned(-acc_q) : $unsigned(acc_q);

	// One restoring step of the averaging divider.
	assign div_shifted = {rem_q, quo_q[DIV_W-1]};
	assign div_trial   = div_shifted - {1'b0, divisor_q};
	assign div_qbit    = !div_trial[DVS_W];
	assign quo_signed  = neg_q ? -$signed(quo_q) : $signed(quo_q);

	// Line error: the averaged weight, or the previous error doubled and saturated when
	// the line has been lost.
	always_comb begin
		if (cnt_q == '0) begin
			if (prev_error_q[15] != prev_error_q[14]) begin
				e_next = prev_error_q[15] ? 16'sh8000 : 16'sh7FFF;
			end else begin
				e_next = {prev_error_q[14:0], 1'b0};
			end
		end else begin
			e_next = quo_signed[15:0];
		end
	end

	// Anti-windup clamp of the accumulated error.
	always_comb begin
		sum_raw = 17'(error_sum_q) + 17'(e_next);
		lim_pos = $signed({2'b00, integ_limit_q});
		lim_neg = -lim_pos;
		if (sum_raw > lim_pos) begin
			sum_next = lim_pos[15:0];
		end else if (sum_raw < lim_neg) begin
			sum_next = lim_neg[15:0];
		end else begin
			sum_next = sum_raw[15:0];
		end
	end

	// Operand selection for the shared multiplier: the three PID products, then the
	// reciprocal product that divides the shifted PID magnitude by 25.
	always_comb begin
		case (state_q)
			ST_MULI: begin
				mul_a = $signed({{(MUL_W - 16){1'b0}}, integ_gain_q});
				mul_b = MUL_W'(error_sum_q);
			end
			ST_MULD: begin
				mul_a = $signed({{(MUL_W - 16){1'b0}}, deriv_gain_q});
				mul_b = MUL_W'(diff_q);
			end
			ST_AMUL: begin
				mul_a = $signed({1'b0, ADJ_RECIP});
				mul_b = $signed({{(MUL_W - ADJ_QIN_W){1'b0}}, quo_q[ADJ_QIN_W-1:0]});
			end
			default: begin
				mul_a = $signed({{(MUL_W - 16){1'b0}}, prop_gain_q});
				mul_b = MUL_W'(err_q);
			end
		endcase
	end

	// Wheel duties from the finished adjustment.
	always_comb begin
		adj      = quo_signed[DUTY_W-1:0];
		base_ext = $signed({{(DUTY_W - 7){1'b0}}, base_speed_q});
		right_d  = shape_duty(base_ext - adj);
		left_d   = shape_duty(base_ext + adj);
		if (right_d > 0) begin
			right_fwd = 6'(div3(right_d[7:0]));
			right_rev = '0;
		end else begin
			right_fwd = '0;
			right_rev = 5'(div3(8'(-right_d)));
		end
		if (left_d > 0) begin
			left_fwd = 6'(div3(left_d[7:0]));
			left_rev = '0;
		end else begin
			left_fwd = '0;
			left_rev = 5'(div3(8'(-left_d)));
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_speed_q  <= BASE_SPEED_RST;
			prop_gain_q   <= PROP_GAIN_RST;
			integ_gain_q  <= INTEG_GAIN_RST;
			deriv_gain_q  <= DERIV_GAIN_RST;
			integ_limit_q <= INTEG_LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_BASE_SPEED:  base_speed_q  <= cfg_data[6:0];
				REG_PROP_GAIN:   prop_gain_q   <= cfg_data;
				REG_INTEG_GAIN:  integ_gain_q  <= cfg_data;
				REG_DERIV_GAIN:  deriv_gain_q  <= cfg_data;
				REG_INTEG_LIMIT: integ_limit_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Sequencer and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			prev_error_q <= '0;
			error_sum_q  <= '0;
			div_cnt_q    <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			// A new result takes the output register as soon as it is free; otherwise the
			// register empties when the receiver takes its transaction.
			if (state_q == ST_SHAPE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q == IDX_LAST) begin
						state_q <= ST_EPREP;
					end
				end
				ST_EPREP: begin
					if (cnt_q == '0) begin
						state_q <= ST_ERR;
					end else begin
						div_cnt_q <= ERR_DIV_STEPS;
						state_q   <= ST_EDIV;
					end
				end
				ST_EDIV: begin
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == DSTEP_W'(1)) begin
						state_q <= ST_ERR;
					end
				end
				ST_ERR: begin
					error_sum_q  <= sum_next;
					prev_error_q <= e_next;
					state_q      <= ST_MULP;
				end
				ST_MULP:  state_q <= ST_MULI;
				ST_MULI:  state_q <= ST_MULD;
				ST_MULD:  state_q <= ST_ACCD;
				ST_ACCD:  state_q <= ST_APREP;
				ST_APREP: state_q <= ST_AMUL;
				ST_AMUL:  state_q <= ST_ADIV;
				ST_ADIV:  state_q <= ST_SHAPE;
				ST_SHAPE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sensor_q <= s_tdata[SENSOR_W-1:0];
				idx_q    <= '0;
				cnt_q    <= '0;
				acc_q    <= '0;
			end
			ST_SCAN: begin
				if (sensor_hit) begin
					acc_q <= acc_q + ACC_W'(weight100(idx_q));
					cnt_q <= cnt_q + 1'b1;
				end
				idx_q <= idx_q + 1'b1;
			end
			ST_EPREP: begin
				neg_q     <= acc_q[ACC_W-1];
				quo_q     <= acc_mag << (DIV_W - ERR_DIV_BITS);
				rem_q     <= '0;
				divisor_q <= DVS_W'(cnt_q);
			end
			ST_EDIV: begin
				rem_q <= div_qbit ? div_trial[DVS_W-1:0] : div_shifted[DVS_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], div_qbit};
			end
			ST_ERR: begin
				err_q  <= e_next;
				diff_q <= 17'(e_next) - 17'(prev_error_q);
			end
			ST_MULP: begin
				acc_q  <= '0;
				prod_q <= mul_a * mul_b;
			end
			ST_MULI, ST_MULD: begin
				acc_q  <= acc_q + ACC_W'(prod_q);
				prod_q <= mul_a * mul_b;
			end
			ST_ACCD: begin
				acc_q <= acc_q + ACC_W'(prod_q);
			end
			ST_APREP: begin
				neg_q <= acc_q[ACC_W-1];
				quo_q <= acc_mag >> ADJ_SHIFT;
			end
			ST_AMUL: begin
				prod_q <= mul_a * mul_b;
			end
			ST_ADIV: begin
				quo_q <= DIV_W'($unsigned(prod_q) >> ADJ_RECIP_SHIFT);
			end
			ST_SHAPE: begin
				if (out_free) begin
					m_tdata_q <= {2'b00, err_q, left_rev, left_fwd, right_rev, right_fwd};
				end
			end
			default: ;
		endcase
	end

	// An accepted tick always starts with the sensor scan.
	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_SCAN))
		else $error("sensor scan did not start after an input transaction");

	// A wheel never drives forward and reverse at once.
	a_dir_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[5:0] == 6'd0 || m_tdata[10:6] == 5'd0) &&
			(m_tdata[16:11] == 6'd0 || m_tdata[21:17] == 5'd0)))
		else $error("wheel duty has both forward and reverse parts");

	// Duties stay within the clamped range.
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[5:0] <= 6'd50 && m_tdata[10:6] <= 5'd16 &&
			m_tdata[16:11] <= 6'd50 && m_tdata[21:17] <= 5'd16))
		else $error("wheel duty outside its range");

	// The divider step counter runs only while the averaging division is in progress.
	a_div_cnt_owner: assert property (@(posedge clk) disable iff (!arst_n)
		(div_cnt_q != '0) |-> (state_q == ST_EDIV))
		else $error("divider counter active outside a division");

	// A new result is only registered once the previous one has gone.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHAPE && m_tvalid_q && !m_tready) |=> (state_q == ST_SHAPE))
		else $error("result left the final stage while the output was stalled");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the line-follower PID steering block.

// One result transaction as it travels on m_tdata, lowest field last.
typedef struct packed {
	logic [1:0]         padding;
	logic signed [15:0] line_error;
	logic [4:0]         left_rev;
	logic [5:0]         left_fwd;
	logic [4:0]         right_rev;
	logic [5:0]         right_fwd;
} wheel_cmd_t;

// Holds a private copy of the steering registers and the PID state, works out the wheel
// command for every accepted sensor reading, and compares the block's commands in order.
class steering_scoreboard;
	localparam int SENSORS = 6;

	logic [6:0]  base_speed;
	logic [15:0] prop_gain;
	logic [15:0] integ_gain;
	logic [15:0] deriv_gain;
	logic [14:0] integ_limit;
	int          prev_error;
	int          error_sum;
	wheel_cmd_t  expected_cmds[$];
	int          ticks_checked;
	int          fails;

	function new();
		base_speed    = lfps_pkg::BASE_SPEED_RST;
		prop_gain     = lfps_pkg::PROP_GAIN_RST;
		integ_gain    = lfps_pkg::INTEG_GAIN_RST;
		deriv_gain    = lfps_pkg::DERIV_GAIN_RST;
		integ_limit   = lfps_pkg::INTEG_LIMIT_RST;
		prev_error    = 0;
		error_sum     = 0;
		ticks_checked = 0;
		fails         = 0;
	endfunction

	function void write_reg(logic [lfps_pkg::CFG_IDX_W-1:0] idx,
			logic [lfps_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			lfps_pkg::REG_BASE_SPEED:  base_speed  = data[6:0];
			lfps_pkg::REG_PROP_GAIN:   prop_gain   = data;
			lfps_pkg::REG_INTEG_GAIN:  integ_gain  = data;
			lfps_pkg::REG_DERIV_GAIN:  deriv_gain  = data;
			lfps_pkg::REG_INTEG_LIMIT: integ_limit = data[14:0];
			default: ;
		endcase
	endfunction

	function longint shape_duty(longint d);
		if (d > 100)
			d = 100 + (d - 100) / 2;
		if (d < 0)
			d = d / 2;
		if (d > 150)
			d = 150;
		if (d < -50)
			d = -50;
		return d;
	endfunction

	function void split_duty(longint d, output logic [5:0] fwd, output logic [4:0] rev);
		if (d > 0) begin
			fwd = 6'(d / 3);
			rev = '0;
		end else begin
			fwd = '0;
			rev = 5'((-d) / 3);
		end
	endfunction

	function wheel_cmd_t steer_for_sensors(logic [5:0] bits);
		int         half;
		int         weighted;
		int         seen;
		int         err;
		int         lim;
		int         summed;
		longint     mix;
		longint     adjust;
		logic       level;
		wheel_cmd_t cmd;
		half     = SENSORS / 2;
		weighted = 0;
		seen     = 0;
		for (int i = 0; i < SENSORS; i++) begin
			// Sensors past the six input bits read as seeing the line.
			level = (i < 6) ? bits[i] : 1'b0;
			if (!level) begin
				weighted += 100 * ((i < half) ? i - half : i - half + 1);
				seen++;
			end
		end
		if (seen == 0) begin
			// Line lost: keep steering the same way, harder each tick.
			err = 2 * prev_error;
			if (err > 32767)
				err = 32767;
			if (err < -32768)
				err = -32768;
		end else begin
			err = weighted / seen;
		end
		lim    = int'(integ_limit);
		summed = error_sum + err;
		if (summed > lim)
			summed = lim;
		if (summed < -lim)
			summed = -lim;
		error_sum = summed;
		mix = longint'(prop_gain) * err + longint'(integ_gain) * error_sum
			+ longint'(deriv_gain) * (err - prev_error);
		adjust     = mix / 25600;
		prev_error = err;
		cmd.padding    = '0;
		cmd.line_error = 16'(err);
		split_duty(shape_duty(longint'(base_speed) - adjust), cmd.right_fwd, cmd.right_rev);
		split_duty(shape_duty(longint'(base_speed) + adjust), cmd.left_fwd, cmd.left_rev);
		return cmd;
	endfunction

	function void note_sensors(logic [5:0] bits);
		expected_cmds.push_back(steer_for_sensors(bits));
	endfunction

	function int outstanding();
		return expected_cmds.size();
	endfunction

	function void log_mismatch(string msg);
		fails++;
		if (fails <= 10)
			$display("%s", msg);
	endfunction

	function void compare_field(string name, logic signed [16:0] want, logic signed [16:0] got);
		if (got !== want)
			log_mismatch($sformatf("tick %0d: %s expected %0d, got %0d",
				ticks_checked, name, want, got));
	endfunction

	function void check_cmd(logic [lfps_pkg::OUT_W-1:0] word);
		wheel_cmd_t got;
		wheel_cmd_t want;
		got = word;
		ticks_checked++;
		if (expected_cmds.size() == 0) begin
			log_mismatch($sformatf("tick %0d: result %h arrived with no tick outstanding",
				ticks_checked, word));
			return;
		end
		want = expected_cmds.pop_front();
		compare_field("right_fwd_duty", want.right_fwd, got.right_fwd);
		compare_field("right_rev_duty", want.right_rev, got.right_rev);
		compare_field("left_fwd_duty", want.left_fwd, got.left_fwd);
		compare_field("left_rev_duty", want.left_rev, got.left_rev);
		compare_field("line_error", want.line_error, got.line_error);
		compare_field("padding", want.padding, got.padding);
	endfunction
endclass

module testbench;
	import lfps_pkg::*;

	localparam int SENSORS          = 6;
	// Length of one tick inside the block.
	localparam int TICK_CYCLES      = SENSORS + 23;
	localparam int NUM_PHASES       = 10;
	localparam int ITEMS_PER_PHASE  = 115;
	// Longest quiet stretch of a correct run is a long sender gap, a whole tick and a long
	// receiver stall back to back; this leaves a wide margin.
	localparam int QUIET_LIMIT      = 5000;
	localparam logic [5:0] LINE_LOST   = 6'h3F;
	localparam logic [5:0] ALL_ON_LINE = 6'h00;
	// Indexes above the last register, whose writes the block must ignore.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = REG_INTEG_LIMIT + 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_W-1:0]      m_tdata;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	steering_scoreboard sb = new();

	// A calm phase runs with neither side idling at all.
	bit calm        = 1'b0;
	int stall_left  = 0;
	int lost_run    = 0;
	int quiet_cycles = 0;

	line_follower_pid_steering #(
		.SENSOR_COUNT(SENSORS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Idle lengths vary at random and are now and then longer than a whole tick, so that
	// gaps land on every stage of the sequencer.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 5)
			return $urandom_range(1, 3);
		if (roll < 9)
			return $urandom_range(4, 12);
		return $urandom_range(13, 150);
	endfunction

	// Sensor readings shaped like a real track: mostly the line under one or two
	// neighbouring sensors, bursts of line loss that drive the error doubling into
	// saturation, and the rest arbitrary or mostly-dark noise.
	function automatic logic [5:0] pick_sensors();
		int kind;
		if (lost_run > 0) begin
			lost_run--;
			return LINE_LOST;
		end
		kind = $urandom_range(0, 99);
		if (kind < 40) begin
			if ($urandom_range(0, 1) == 0)
				return ~(6'b000001 << $urandom_range(0, 5));
			return ~(6'b000011 << $urandom_range(0, 4));
		end
		if (kind < 55) begin
			lost_run = $urandom_range(0, 9);
			return LINE_LOST;
		end
		if (kind < 85)
			return 6'($urandom);
		return 6'($urandom & $urandom);
	endfunction

	function automatic logic [15:0] pick_gain();
		if ($urandom_range(0, 5) == 0)
			return 16'($urandom);
		return 16'($urandom_range(0, 4096));
	endfunction

	// Entered at a rising edge; returns at the edge where the transaction is taken.
	task automatic send_sensors(input logic [5:0] bits);
		int gap;
		gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_W - SENSOR_W){1'b0}}, bits};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_sensors(bits);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	// Writes every register, plus one stray write to an unused index, back to back.
	task automatic configure(input logic [15:0] base, input logic [15:0] kp,
			input logic [15:0] ki, input logic [15:0] kd, input logic [15:0] lim);
		write_reg(REG_BASE_SPEED, base);
		write_reg(REG_PROP_GAIN, kp);
		write_reg(REG_INTEG_GAIN, ki);
		write_reg(REG_DERIV_GAIN, kd);
		write_reg(REG_INTEG_LIMIT, lim);
		write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), 16'($urandom));
		cfg_wr_en <= 1'b0;
	endtask

	// Receiving side: checks each result transaction and stalls at random.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_cmd(m_tdata);
		if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0)
			stall_left = pick_gap();
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Counts cycles in which nothing moves on any port.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("[line_follower_pid_steering] ERROR");
		$finish;
	end

	initial begin
		logic [6:0] base;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset defaults: no line at all with a zero history, the
		// whole array on the line, each sensor alone, then line loss after a hard right
		// and after a hard left, long enough for the doubled error to saturate both ways.
		send_sensors(LINE_LOST);
		send_sensors(ALL_ON_LINE);
		for (int i = 0; i < SENSORS; i++)
			send_sensors(~(6'b000001 << i));
		repeat (8) send_sensors(LINE_LOST);
		send_sensors(6'b111110);
		repeat (8) send_sensors(LINE_LOST);
		s_tvalid <= 1'b0;

		for (int p = 0; p < NUM_PHASES; p++) begin
			// Registers may only change while no tick is in flight.
			while (sb.outstanding() != 0)
				@(posedge clk);
			calm = ($urandom_range(0, 4) == 0);
			case (p)
				// All ones: base speed and limit beyond their nominal range after masking.
				0: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				1: configure(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
				2: configure(16'd100, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
				3: configure(16'd0, 16'h0000, 16'hFFFF, 16'h0000, 16'h7FFF);
				default: begin
					base = ($urandom_range(0, 4) == 0) ? 7'd127 : 7'($urandom_range(0, 100));
					// Junk in the unused upper bits must not reach the register.
					configure({9'($urandom), base}, pick_gain(), pick_gain(), pick_gain(),
						($urandom_range(0, 3) == 0) ? 16'($urandom)
							: 16'($urandom_range(0, 4000)));
				end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_sensors(pick_sensors());
			s_tvalid <= 1'b0;
		end

		while (sb.outstanding() != 0)
			@(posedge clk);
		// Leave room for any stray result the block might still produce.
		repeat (TICK_CYCLES + 10) @(posedge clk);
		if (sb.fails == 0)
			$display("[line_follower_pid_steering] OK");
		else
			$display("[line_follower_pid_steering] ERROR");
		$finish;
	end

endmodule
